/* sv/bfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfl_pkg
// Shared sizes and codes of the buddy free-list engine.
// ----------------------------------------------------------------------------
package bfl_pkg;

    localparam int FRAME_COUNT = 4096;
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int MAX_ORDER   = 10;
    localparam int ORDER_W     = 4;
    localparam int ZONE_W      = 13;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SPLIT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COALESCE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FREE  = 2'd3;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 13'd4096;

endpackage

/* sv/buddy_free_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_free_list_engine
// Per-order doubly linked free lists of a buddy page allocator.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the frame order and frame
// used stores, during which no word is accepted. Each word is then worked by a
// sequencer against link and frame stores that each have one write port and a
// registered read port. A push of a frame that is already free first unlinks
// it from its current list. Split pushes each lower buddy at its order, and
// coalesce merges level by level while the buddy is free. A rejected word, or
// a remove or coalesce of a frame that is not free, goes to the result stage.
// After the result is loaded the block returns to idle before the next word.
// One word is worked at a time; the next word is taken while a finished
// result waits at the output register.
module buddy_free_list_engine
    import bfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [ZONE_W-1:0]   cfg_wr_data,     // zone_pages
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,    // frame[11:0], order[15:12], target_order[19:16]
    input  logic [KIND_W-1:0]   s_axis_tuser,    // kind[2:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,    // result_frame[11:0], result_order[15:12]
    output logic [STATUS_W-1:0] m_axis_tuser     // status[1:0]
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DEC, S_CHK, S_SP_START, S_SP_LOOP,
        S_CO_TEST, S_CO_EV, S_CO_UN2, S_CO_PUSH,
        S_U_RD, S_U_EV, S_P_RD, S_P_EV, S_P_LINK, S_P_LINK2, S_DONE
    } state_t;

    state_t              state_reg, cont_reg;
    logic [FRAME_W:0]    clr_cnt_reg;
    logic [ZONE_W-1:0]   zone_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [FRAME_W-1:0]  frame_reg, cur_f_reg, s_reg, b_reg, bd_reg, n_reg;
    logic [ORDER_W-1:0]  ord_reg, tgt_reg, cur_o_reg, push_o_reg, idx_reg;
    logic                in_push_reg;
    logic [FRAME_W-1:0]  rf_reg;
    logic [ORDER_W-1:0]  ro_reg;
    logic [STATUS_W-1:0] st_reg;
    logic                out_valid_reg;
    logic [FRAME_W-1:0]  out_frame_reg;
    logic [ORDER_W-1:0]  out_order_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [MAX_ORDER:0]  hv_reg;
    logic [FRAME_W-1:0]  hf_reg [0:MAX_ORDER];

    logic [FRAME_W-1:0]  prev_mem  [0:FRAME_COUNT-1];
    logic [FRAME_W-1:0]  next_mem  [0:FRAME_COUNT-1];
    logic [ORDER_W-1:0]  order_mem [0:FRAME_COUNT-1];
    logic                used_mem  [0:FRAME_COUNT-1];
    logic [FRAME_W-1:0]  prev_q, next_q;
    logic [ORDER_W-1:0]  order_q;
    logic                used_q;

    logic [FRAME_W-1:0]  rd_addr;
    logic                prev_we, next_we, order_we, used_we;
    logic [FRAME_W-1:0]  prev_wa, prev_wd, next_wa, next_wd, order_wa, used_wa;
    logic [ORDER_W-1:0]  order_wd;
    logic                used_wd;

    logic [ORDER_W-1:0]  hidx_raw, hidx;
    logic                hv_sel;
    logic [FRAME_W-1:0]  hf_sel;
    logic [FRAME_W-1:0]  p_lnk, n_lnk, push_n, sz, bd, split_b;
    logic [ZONE_W-1:0]   lim, b_end, bd_end;
    logic                co_ok;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_order_reg, out_frame_reg};
    assign m_axis_tuser  = out_status_reg;

    assign p_lnk = prev_q;
    assign n_lnk = next_q;

    always_comb
    begin
        case (state_reg)
            S_U_EV:  hidx_raw = cur_o_reg;
            S_P_LINK: hidx_raw = push_o_reg;
            default: hidx_raw = ord_reg;
        endcase
        hidx   = (hidx_raw > ORDER_W'(MAX_ORDER)) ? '0 : hidx_raw;
        hv_sel = hv_reg[hidx];
        hf_sel = hf_reg[hidx];
        push_n = hv_sel ? hf_sel : cur_f_reg;
    end

    // coalesce bounds
    always_comb
    begin
        lim     = (zone_reg < ZONE_W'(FRAME_COUNT)) ? zone_reg : ZONE_W'(FRAME_COUNT);
        sz      = FRAME_W'(1) << idx_reg;
        bd      = b_reg ^ sz;
        b_end   = {1'b0, b_reg} + {1'b0, sz};
        bd_end  = {1'b0, bd} + {1'b0, sz};
        co_ok   = (idx_reg < ORDER_W'(MAX_ORDER))
                  && ({1'b0, b_reg} < lim) && (b_end <= lim)
                  && ({1'b0, bd} < lim) && (bd_end <= lim);
        split_b = s_reg ^ sz;
    end

    always_comb
    begin
        case (state_reg)
            S_DEC:     rd_addr = frame_reg;
            S_CO_TEST: rd_addr = bd;
            default:   rd_addr = cur_f_reg;
        endcase
    end

    // store write ports
    always_comb
    begin
        prev_we  = 1'b0; prev_wa  = cur_f_reg; prev_wd  = cur_f_reg;
        next_we  = 1'b0; next_wa  = cur_f_reg; next_wd  = push_n;
        order_we = 1'b0; order_wa = cur_f_reg; order_wd = push_o_reg;
        used_we  = 1'b0; used_wa  = cur_f_reg; used_wd  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                order_we = 1'b1; order_wa = clr_cnt_reg[FRAME_W-1:0]; order_wd = '0;
                used_we  = 1'b1; used_wa  = clr_cnt_reg[FRAME_W-1:0]; used_wd  = 1'b1;
            end
            S_U_EV:
            begin
                next_we = 1'b1; next_wa = p_lnk;
                next_wd = (n_lnk != cur_f_reg) ? n_lnk : p_lnk;
                prev_we = 1'b1; prev_wa = n_lnk;
                prev_wd = (p_lnk != cur_f_reg) ? p_lnk : n_lnk;
                used_we = 1'b1; used_wd = 1'b1;
            end
            S_P_LINK:
            begin
                prev_we  = 1'b1;
                next_we  = 1'b1;
                order_we = 1'b1;
                used_we  = 1'b1;
            end
            S_P_LINK2:
            begin
                prev_we = 1'b1; prev_wa = n_reg;
            end
            default:
            begin
                prev_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (order_we)
        begin
            order_mem[order_wa] <= order_wd;
        end
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        prev_q  <= prev_mem[rd_addr];
        next_q  <= next_mem[rd_addr];
        order_q <= order_mem[rd_addr];
        used_q  <= used_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cont_reg      <= S_DONE;
            clr_cnt_reg   <= '0;
            zone_reg      <= ZONE_RESET;
            hv_reg        <= '0;
            in_push_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                zone_reg <= cfg_wr_data;
            end
            // a finished word reloads the output register from S_DONE
            if (out_valid_reg && m_axis_tready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == (FRAME_W+1)'(FRAME_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        kind_reg  <= s_axis_tuser;
                        frame_reg <= s_axis_tdata[11:0];
                        ord_reg   <= s_axis_tdata[15:12];
                        tgt_reg   <= s_axis_tdata[19:16];
                        rf_reg    <= '0;
                        ro_reg    <= '0;
                        st_reg    <= ST_OK;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    cont_reg <= S_DONE;
                    if (kind_reg > KIND_COALESCE || ord_reg > ORDER_W'(MAX_ORDER))
                    begin
                        st_reg    <= ST_BAD_ORDER;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        case (kind_reg)
                            KIND_PUSH:
                            begin
                                cur_f_reg  <= frame_reg;
                                push_o_reg <= ord_reg;
                                rf_reg     <= frame_reg;
                                ro_reg     <= ord_reg;
                                state_reg  <= S_P_RD;
                            end
                            KIND_POP:
                            begin
                                if (!hv_sel)
                                begin
                                    st_reg    <= ST_EMPTY;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    rf_reg    <= hf_sel;
                                    ro_reg    <= ord_reg;
                                    cur_f_reg <= hf_sel;
                                    cur_o_reg <= ord_reg;
                                    state_reg <= S_U_RD;
                                end
                            end
                            KIND_SPLIT:
                            begin
                                if (tgt_reg >= ord_reg)
                                begin
                                    st_reg    <= ST_BAD_ORDER;
                                    state_reg <= S_DONE;
                                end
                                else if (!hv_sel)
                                begin
                                    st_reg    <= ST_EMPTY;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    s_reg     <= hf_sel;
                                    cur_f_reg <= hf_sel;
                                    cur_o_reg <= ord_reg;
                                    cont_reg  <= S_SP_START;
                                    state_reg <= S_U_RD;
                                end
                            end
                            default:
                            begin
                                // remove and coalesce: frame store read is under way
                                state_reg <= S_CHK;
                            end
                        endcase
                    end
                end
                S_CHK:
                begin
                    if (used_q || order_q != ord_reg)
                    begin
                        st_reg    <= ST_NOT_FREE;
                        state_reg <= S_DONE;
                    end
                    else if (kind_reg == KIND_REMOVE)
                    begin
                        rf_reg    <= frame_reg;
                        ro_reg    <= ord_reg;
                        cur_f_reg <= frame_reg;
                        cur_o_reg <= ord_reg;
                        state_reg <= S_U_RD;
                    end
                    else
                    begin
                        b_reg     <= frame_reg;
                        idx_reg   <= ord_reg;
                        state_reg <= S_CO_TEST;
                    end
                end
                S_SP_START:
                begin
                    cur_f_reg  <= s_reg;
                    push_o_reg <= tgt_reg;
                    idx_reg    <= tgt_reg;
                    cont_reg   <= S_SP_LOOP;
                    state_reg  <= S_P_RD;
                end
                S_SP_LOOP:
                begin
                    if (idx_reg < ord_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if ({1'b0, split_b} < (FRAME_W+1)'(FRAME_COUNT))
                        begin
                            cur_f_reg  <= split_b;
                            push_o_reg <= idx_reg;
                            state_reg  <= S_P_RD;
                        end
                    end
                    else
                    begin
                        rf_reg    <= s_reg;
                        ro_reg    <= tgt_reg;
                        state_reg <= S_DONE;
                    end
                end
                S_CO_TEST:
                begin
                    if (co_ok)
                    begin
                        bd_reg    <= bd;
                        state_reg <= S_CO_EV;
                    end
                    else
                    begin
                        rf_reg    <= b_reg;
                        ro_reg    <= idx_reg;
                        state_reg <= S_DONE;
                    end
                end
                S_CO_EV:
                begin
                    if (order_q != idx_reg || used_q)
                    begin
                        rf_reg    <= b_reg;
                        ro_reg    <= idx_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cur_f_reg <= b_reg;
                        cur_o_reg <= idx_reg;
                        cont_reg  <= S_CO_UN2;
                        state_reg <= S_U_RD;
                    end
                end
                S_CO_UN2:
                begin
                    cur_f_reg <= bd_reg;
                    cont_reg  <= S_CO_PUSH;
                    state_reg <= S_U_RD;
                end
                S_CO_PUSH:
                begin
                    // merged block starts at the lower buddy
                    if (bd_reg < b_reg)
                    begin
                        b_reg     <= bd_reg;
                        cur_f_reg <= bd_reg;
                    end
                    else
                    begin
                        cur_f_reg <= b_reg;
                    end
                    idx_reg    <= idx_reg + 1'b1;
                    push_o_reg <= idx_reg + 1'b1;
                    cont_reg   <= S_CO_TEST;
                    state_reg  <= S_P_RD;
                end
                S_U_RD:
                begin
                    state_reg <= S_U_EV;
                end
                S_U_EV:
                begin
                    if (hv_sel && hf_sel == cur_f_reg)
                    begin
                        if (n_lnk == cur_f_reg)
                        begin
                            hv_reg[hidx] <= 1'b0;
                        end
                        else
                        begin
                            hf_reg[hidx] <= n_lnk;
                        end
                    end
                    state_reg <= in_push_reg ? S_P_LINK : cont_reg;
                end
                S_P_RD:
                begin
                    state_reg <= S_P_EV;
                end
                S_P_EV:
                begin
                    if (!used_q)
                    begin
                        // already free: drop it from its current list first
                        cur_o_reg   <= order_q;
                        in_push_reg <= 1'b1;
                        state_reg   <= S_U_RD;
                    end
                    else
                    begin
                        state_reg <= S_P_LINK;
                    end
                end
                S_P_LINK:
                begin
                    n_reg        <= push_n;
                    hf_reg[hidx] <= cur_f_reg;
                    hv_reg[hidx] <= 1'b1;
                    in_push_reg  <= 1'b0;
                    state_reg    <= S_P_LINK2;
                end
                S_P_LINK2:
                begin
                    state_reg <= cont_reg;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_frame_reg  <= rf_reg;
                        out_order_reg  <= ro_reg;
                        out_status_reg <= st_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
